@@ src/acctilt_pkg.sv @@
// ---------------------------------------------------------------------------
// acctilt_pkg
// Shared constants for the accelerometer tilt angle pipeline.
// ---------------------------------------------------------------------------
package acctilt_pkg;

   localparam int ACC_W       = 27;
   localparam int TAB_LEN     = 24;
   localparam int GUARD_SHIFT = 8;
   localparam int OUT_SHIFT   = 9;
   localparam int ANGLE_W     = 17;
   localparam int ROLL_W      = 16;
   localparam int PITCH_W     = 17;
   localparam int OFFSET_W    = 15;
   localparam int RSP_W       = ((ROLL_W + PITCH_W + 7) / 8) * 8;
   localparam int CSR_INDEX_W = 8;

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_ROLL_OFFSET  = csr_index_type'(0);
   localparam csr_index_type CSR_PITCH_OFFSET = csr_index_type'(1);

   // degrees * 2^16
   localparam acc_type DEG90      = acc_type'(90 * 65536);
   localparam acc_type ROUND_HALF = acc_type'(2 ** (OUT_SHIFT - 1));

   // atan(2^-i) in degrees * 2^16
   localparam acc_type ATAN_TAB [TAB_LEN] = '{
      acc_type'(2949120), acc_type'(1740967), acc_type'(919879), acc_type'(466945),
      acc_type'(234379),  acc_type'(117304),  acc_type'(58666),  acc_type'(29335),
      acc_type'(14668),   acc_type'(7334),    acc_type'(3667),   acc_type'(1833),
      acc_type'(917),     acc_type'(458),     acc_type'(229),    acc_type'(115),
      acc_type'(57),      acc_type'(29),      acc_type'(14),     acc_type'(7),
      acc_type'(4),       acc_type'(2),       acc_type'(1),      acc_type'(0)
   };

endpackage

@@ src/accel_tilt_angles.sv @@
// ---------------------------------------------------------------------------
// accel_tilt_angles
// Roll and pitch tilt angles from one accelerometer sample, plus offsets.
//
//   channel  direction  transfer on               payload
//   req_*    in         req_tvalid & req_tready   tdata: accel_x, accel_y, accel_z
//   rsp_*    out        rsp_tvalid & rsp_tready   tdata: roll_angle, pitch_angle
//   csr_*    in         csr_valid & csr_ready     csr_index, csr_data
//
// One sample per cycle unless the pipeline freezes (below); the square root
// resolves one root bit per stage and feeds the CORDIC.
// Synchronous reset clears all valid bits and both offsets.
// The pipeline freezes only while a result sits unaccepted in the output
// register and another waits behind it; req_tready follows that freeze.
// ---------------------------------------------------------------------------
module accel_tilt_angles #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // accel_x, accel_y, accel_z
   input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]        req_tdata,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // roll_angle, pitch_angle
   output logic [acctilt_pkg::RSP_W-1:0]              rsp_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [acctilt_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [acctilt_pkg::OFFSET_W-1:0]           csr_data
);

   localparam int W      = SAMPLE_WIDTH;
   localparam int RW     = W + acctilt_pkg::GUARD_SHIFT;
   localparam int VW     = W + acctilt_pkg::GUARD_SHIFT + 3;
   localparam int EXT_W  = VW - RW;
   localparam int SIDE_W = 3 * W;
   localparam int STEPS  = (CORDIC_STEPS > acctilt_pkg::TAB_LEN) ?
                           acctilt_pkg::TAB_LEN : CORDIC_STEPS;
   localparam int GS     = acctilt_pkg::GUARD_SHIFT;
   localparam int AW     = acctilt_pkg::ANGLE_W;
   localparam int OW     = acctilt_pkg::OFFSET_W;

   logic en;

   // configuration
   logic [OW-1:0] roll_off_ff;
   logic [OW-1:0] pitch_off_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_off_ff  <= '0;
         pitch_off_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            acctilt_pkg::CSR_ROLL_OFFSET:  roll_off_ff  <= csr_data;
            acctilt_pkg::CSR_PITCH_OFFSET: pitch_off_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: squares
   logic signed [W-1:0]   in_y, in_z;
   logic signed [2*W-1:0] sq_y_in, sq_z_in;
   logic                  s1_vld_ff;
   logic [2*W-1:0]        s1_sqy_ff, s1_sqz_ff;
   logic [SIDE_W-1:0]     s1_side_ff;

   assign in_y    = req_tdata[2*W-1:W];
   assign in_z    = req_tdata[3*W-1:2*W];
   assign sq_y_in = in_y * in_y;
   assign sq_z_in = in_z * in_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sqy_ff  <= $unsigned(sq_y_in);
         s1_sqz_ff  <= $unsigned(sq_z_in);
         s1_side_ff <= req_tdata[SIDE_W-1:0];
      end
   end

   // stage 2: sum of squares
   logic              s2_vld_ff;
   logic [2*W-1:0]    s2_sum_ff;
   logic [SIDE_W-1:0] s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sum_ff  <= s1_sqy_ff + s1_sqz_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   // square root of (y*y + z*z) * 2^(2*GS)
   logic              sq_vld;
   logic [RW-1:0]     sq_root;
   logic [SIDE_W-1:0] sq_side;

   acctilt_isqrt #(
      .RW     (RW),
      .SIDE_W (SIDE_W)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s2_vld_ff),
      .in_radicand ({s2_sum_ff, {(2*GS){1'b0}}}),
      .in_side     (s2_side_ff),
      .out_valid   (sq_vld),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // CORDIC operands, samples scaled by 2^GS
   logic [W-1:0]         ax, ay, az;
   logic signed [VW-1:0] roll_x, roll_y, pitch_x, pitch_y, ay_sc;

   assign ax      = sq_side[W-1:0];
   assign ay      = sq_side[2*W-1:W];
   assign az      = sq_side[3*W-1:2*W];
   assign roll_x  = {{EXT_W{1'b0}}, sq_root};
   assign roll_y  = {{EXT_W{ax[W-1]}}, ax, {GS{1'b0}}};
   assign pitch_x = {{EXT_W{az[W-1]}}, az, {GS{1'b0}}};
   assign ay_sc   = {{EXT_W{ay[W-1]}}, ay, {GS{1'b0}}};
   assign pitch_y = -ay_sc;

   logic                 roll_vld, pitch_vld;
   logic signed [AW-1:0] roll_ang, pitch_ang;

   acctilt_cordic #(
      .VW    (VW),
      .STEPS (STEPS)
   ) u_cordic_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_vld),
      .in_x      (roll_x),
      .in_y      (roll_y),
      .out_valid (roll_vld),
      .out_angle (roll_ang)
   );

   acctilt_cordic #(
      .VW    (VW),
      .STEPS (STEPS)
   ) u_cordic_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_vld),
      .in_x      (pitch_x),
      .in_y      (pitch_y),
      .out_valid (pitch_vld),
      .out_angle (pitch_ang)
   );

   // offset add into output register
   logic                        last_vld;
   logic signed [AW-1:0]        roll_sum, pitch_sum;
   logic                        rsp_vld_ff;
   logic [acctilt_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   assign last_vld  = roll_vld & pitch_vld;
   assign roll_sum  = roll_ang + {{(AW-OW){roll_off_ff[OW-1]}}, roll_off_ff};
   assign pitch_sum = pitch_ang + {{(AW-OW){pitch_off_ff[OW-1]}}, pitch_off_ff};

   assign rsp_data_in = {
      {(acctilt_pkg::RSP_W - acctilt_pkg::ROLL_W - acctilt_pkg::PITCH_W){1'b0}},
      pitch_sum[acctilt_pkg::PITCH_W-1:0],
      roll_sum[acctilt_pkg::ROLL_W-1:0]
   };

   assign en = !(rsp_vld_ff && !rsp_tready && last_vld);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         if (last_vld) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && last_vld) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ src/acctilt_isqrt.sv @@
// ---------------------------------------------------------------------------
// acctilt_isqrt
// Pipelined floor square root, one root bit per stage, with sideband data.
// ---------------------------------------------------------------------------
module acctilt_isqrt #(
   parameter int RW     = 24,
   parameter int SIDE_W = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [2*RW-1:0]   in_radicand,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic [RW-1:0]     vld_ff;
   logic [RW-1:0]     vld_in;
   logic [RW+1:0]     rem_ff   [RW];
   logic [RW-1:0]     root_ff  [RW];
   logic [2*RW-1:0]   rad_ff   [RW];
   logic [SIDE_W-1:0] side_ff  [RW];

   logic [RW+1:0]     rem_src  [RW];
   logic [RW-1:0]     root_src [RW];
   logic [2*RW-1:0]   rad_src  [RW];
   logic [SIDE_W-1:0] side_src [RW];

   logic [RW+1:0]     rem_sh   [RW];
   logic [RW+1:0]     trial    [RW];
   logic [RW-1:0]     take;
   logic [RW+1:0]     rem_in   [RW];
   logic [RW-1:0]     root_in  [RW];
   logic [2*RW-1:0]   rad_in   [RW];

   assign vld_in = {vld_ff[RW-2:0], in_valid};

   for (genvar k = 0; k < RW; k++) begin : g_step
      if (k == 0) begin : g_first
         assign rem_src[k]  = '0;
         assign root_src[k] = '0;
         assign rad_src[k]  = in_radicand;
         assign side_src[k] = in_side;
      end else begin : g_next
         assign rem_src[k]  = rem_ff[k-1];
         assign root_src[k] = root_ff[k-1];
         assign rad_src[k]  = rad_ff[k-1];
         assign side_src[k] = side_ff[k-1];
      end

      assign rem_sh[k]  = {rem_src[k][RW-1:0], rad_src[k][2*RW-1 -: 2]};
      assign trial[k]   = {root_src[k], 2'b01};
      assign take[k]    = (rem_sh[k] >= trial[k]);
      assign rem_in[k]  = take[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
      assign root_in[k] = {root_src[k][RW-2:0], take[k]};
      assign rad_in[k]  = {rad_src[k][2*RW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         side_ff <= side_src;
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

@@ src/acctilt_cordic.sv @@
// ---------------------------------------------------------------------------
// acctilt_cordic
// Pipelined vectoring CORDIC: four-quadrant atan2(y, x) in degrees * 128.
// ---------------------------------------------------------------------------
module acctilt_cordic #(
   parameter int VW    = 27,
   parameter int STEPS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [VW-1:0]                   in_x,
   input  logic signed [VW-1:0]                   in_y,
   output logic                                   out_valid,
   output logic signed [acctilt_pkg::ANGLE_W-1:0] out_angle
);

   // pre-rotation stage
   logic                  pre_vld_ff;
   logic signed [VW-1:0]  pre_x_ff, pre_x_in;
   logic signed [VW-1:0]  pre_y_ff, pre_y_in;
   acctilt_pkg::acc_type  pre_acc_ff, pre_acc_in;
   logic                  pre_zero_ff, pre_zero_in;

   always_comb begin
      pre_zero_in = (in_x == '0) && (in_y == '0);
      pre_x_in    = in_x;
      pre_y_in    = in_y;
      pre_acc_in  = '0;
      if (in_x[VW-1]) begin
         if (!in_y[VW-1]) begin
            pre_x_in   = in_y;
            pre_y_in   = -in_x;
            pre_acc_in = acctilt_pkg::DEG90;
         end else begin
            pre_x_in   = -in_y;
            pre_y_in   = in_x;
            pre_acc_in = -acctilt_pkg::DEG90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else if (en) begin
         pre_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_x_ff    <= pre_x_in;
         pre_y_ff    <= pre_y_in;
         pre_acc_ff  <= pre_acc_in;
         pre_zero_ff <= pre_zero_in;
      end
   end

   // micro-rotation stages
   logic [STEPS-1:0]     it_vld_ff, it_vld_in;
   logic [STEPS-1:0]     it_zero_ff, it_zero_in;
   logic signed [VW-1:0] it_x_ff   [STEPS];
   logic signed [VW-1:0] it_y_ff   [STEPS];
   acctilt_pkg::acc_type it_acc_ff [STEPS];

   logic signed [VW-1:0] x_src     [STEPS];
   logic signed [VW-1:0] y_src     [STEPS];
   acctilt_pkg::acc_type acc_src   [STEPS];
   logic signed [VW-1:0] xs        [STEPS];
   logic signed [VW-1:0] ys        [STEPS];
   logic [STEPS-1:0]     pos;
   logic signed [VW-1:0] it_x_in   [STEPS];
   logic signed [VW-1:0] it_y_in   [STEPS];
   acctilt_pkg::acc_type it_acc_in [STEPS];

   assign it_vld_in  = {it_vld_ff[STEPS-2:0], pre_vld_ff};
   assign it_zero_in = {it_zero_ff[STEPS-2:0], pre_zero_ff};

   for (genvar k = 0; k < STEPS; k++) begin : g_iter
      if (k == 0) begin : g_first
         assign x_src[k]   = pre_x_ff;
         assign y_src[k]   = pre_y_ff;
         assign acc_src[k] = pre_acc_ff;
      end else begin : g_next
         assign x_src[k]   = it_x_ff[k-1];
         assign y_src[k]   = it_y_ff[k-1];
         assign acc_src[k] = it_acc_ff[k-1];
      end

      assign xs[k]  = x_src[k] >>> k;
      assign ys[k]  = y_src[k] >>> k;
      assign pos[k] = !y_src[k][VW-1] && (y_src[k] != '0);

      assign it_x_in[k]   = pos[k] ? (x_src[k] + ys[k]) : (x_src[k] - ys[k]);
      assign it_y_in[k]   = pos[k] ? (y_src[k] - xs[k]) : (y_src[k] + xs[k]);
      assign it_acc_in[k] = pos[k] ? (acc_src[k] + acctilt_pkg::ATAN_TAB[k])
                                   : (acc_src[k] - acctilt_pkg::ATAN_TAB[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         it_vld_ff <= '0;
      end else if (en) begin
         it_vld_ff <= it_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it_zero_ff <= it_zero_in;
         it_x_ff    <= it_x_in;
         it_y_ff    <= it_y_in;
         it_acc_ff  <= it_acc_in;
      end
   end

   // rounding stage: degrees * 2^16 -> degrees * 128, round half up
   acctilt_pkg::acc_type                   rnd;
   acctilt_pkg::acc_type                   rnd_shr;
   logic                                   ang_vld_ff;
   logic signed [acctilt_pkg::ANGLE_W-1:0] ang_ff, ang_in;

   assign rnd     = it_acc_ff[STEPS-1] + acctilt_pkg::ROUND_HALF;
   assign rnd_shr = rnd >>> acctilt_pkg::OUT_SHIFT;
   assign ang_in  = it_zero_ff[STEPS-1] ? '0 : rnd_shr[acctilt_pkg::ANGLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_vld_ff <= 1'b0;
      end else if (en) begin
         ang_vld_ff <= it_vld_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= ang_in;
      end
   end

   assign out_valid = ang_vld_ff;
   assign out_angle = ang_ff;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for accel_tilt_angles. Accelerometer samples go in on
// the req stream, roll and pitch come back on the rsp stream and are matched
// in order against a bit-exact CORDIC tilt predictor. A directed table of
// corner samples runs first, then random samples under several offset
// settings, with random idle cycles on both streams.
// ---------------------------------------------------------------------------
module testbench;

   localparam int SAMPLE_W      = 16;
   localparam int CORDIC_STEPS  = 16;
   localparam int LATENCY       = SAMPLE_W + CORDIC_STEPS + 13;
   localparam int SETTLE_CYCLES = LATENCY + 20;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 72;
   localparam int DIRECTED_N    = 23;
   localparam int OFFSET_MAX    = 11520;

   localparam int PHASE_ROLL [PHASES] =
      '{OFFSET_MAX, -OFFSET_MAX, OFFSET_MAX, -OFFSET_MAX, 0, 0, 0};
   localparam int PHASE_PITCH [PHASES] =
      '{-OFFSET_MAX, OFFSET_MAX, OFFSET_MAX, -OFFSET_MAX, 0, 0, 0};

   localparam longint Q16_RIGHT_ANGLE = 90 * 65536;
   localparam acctilt_pkg::csr_index_type CSR_FIRST_UNUSED =
      acctilt_pkg::csr_index_type'(2);

   // atan(2^-i) in degrees * 2^16
   localparam longint ATAN_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_z;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_x;
   } sample_type;

   typedef struct packed {
      logic signed [acctilt_pkg::PITCH_W-1:0] pitch;
      logic signed [acctilt_pkg::ROLL_W-1:0]  roll;
   } angles_type;

   typedef struct {
      int x;
      int y;
      int z;
      bit known;
      int roll;
      int pitch;
   } corner_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [3*SAMPLE_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [acctilt_pkg::RSP_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [acctilt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [acctilt_pkg::OFFSET_W-1:0] csr_data = '0;

   // typed-in expectation traveling with the current sample
   logic req_known = 1'b0;
   angles_type req_known_angles = '0;

   logic signed [acctilt_pkg::OFFSET_W-1:0] roll_trim = '0;
   logic signed [acctilt_pkg::OFFSET_W-1:0] pitch_trim = '0;

   angles_type pending_angles [$];
   angles_type got_angles;
   angles_type want_angles;
   int error_count = 0;
   int cycle_count = 0;
   int rsp_hold = 0;
   int rsp_gap;
   bit rsp_steady = 1'b0;
   bit req_steady = 1'b0;

   corner_row_type corner_rows [DIRECTED_N] = '{
      '{0, 0, 0, 1'b1, 0, 0},
      '{32767, 0, 0, 1'b0, 0, 0},
      '{-32768, 0, 0, 1'b0, 0, 0},
      '{0, 32767, 0, 1'b0, 0, 0},
      '{0, -32768, 0, 1'b0, 0, 0},
      '{0, 0, 32767, 1'b0, 0, 0},
      '{0, 0, -32768, 1'b0, 0, 0},
      '{0, 0, -1, 1'b0, 0, 0},
      '{0, 1, -32768, 1'b0, 0, 0},
      '{0, -1, -32768, 1'b0, 0, 0},
      '{32767, 32767, 32767, 1'b0, 0, 0},
      '{-32768, -32768, -32768, 1'b0, 0, 0},
      '{32767, -32768, 32767, 1'b0, 0, 0},
      '{-32768, 32767, -32768, 1'b0, 0, 0},
      '{1, 0, 0, 1'b0, 0, 0},
      '{-1, 0, 0, 1'b0, 0, 0},
      '{0, 1, 0, 1'b0, 0, 0},
      '{0, -1, 0, 1'b0, 0, 0},
      '{1, 1, 1, 1'b0, 0, 0},
      '{-1, -1, -1, 1'b0, 0, 0},
      '{21845, -21846, 21845, 1'b0, 0, 0},
      '{-21846, 21845, -21846, 1'b0, 0, 0},
      '{100, -200, -300, 1'b0, 0, 0}
   };

   accel_tilt_angles #(
      .SAMPLE_WIDTH(SAMPLE_W),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // atan2(y, x) in degrees * 128
   function automatic longint vector_angle(longint x, longint y);
      longint acc;
      longint t;
      longint xs;
      longint ys;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            acc = Q16_RIGHT_ANGLE;
         end else begin
            x = -y;
            y = t;
            acc = -Q16_RIGHT_ANGLE;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            acc = acc + ATAN_Q16[i];
         end else begin
            x = x - ys;
            y = y + xs;
            acc = acc - ATAN_Q16[i];
         end
      end
      return (acc + 256) >>> 9;
   endfunction

   function automatic angles_type tilt_angles_of(sample_type s);
      longint ax;
      longint ay;
      longint az;
      longint root;
      longint roll;
      longint pitch;
      longint unsigned sumsq;
      angles_type r;
      ax = $signed(s.accel_x);
      ay = $signed(s.accel_y);
      az = $signed(s.accel_z);
      sumsq = ay * ay + az * az;
      root = floor_sqrt(sumsq << 16);
      roll = vector_angle(root, ax * 256) + $signed(roll_trim);
      pitch = vector_angle(az * 256, -ay * 256) + $signed(pitch_trim);
      r.roll = roll[acctilt_pkg::ROLL_W-1:0];
      r.pitch = pitch[acctilt_pkg::PITCH_W-1:0];
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] corner_value();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'hffff;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'h7fff;
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] near_zero();
      return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      s.accel_x = SAMPLE_W'($urandom);
      s.accel_y = SAMPLE_W'($urandom);
      s.accel_z = SAMPLE_W'($urandom);
      case ($urandom_range(0, 9))
         6: begin
            s.accel_x = near_zero();
            s.accel_y = near_zero();
            s.accel_z = near_zero();
         end
         7: begin
            s.accel_x = corner_value();
            s.accel_y = corner_value();
            s.accel_z = corner_value();
         end
         8: s.accel_y = '0;
         9: begin
            s.accel_x = corner_value();
            s.accel_z = near_zero();
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   task automatic send_sample(sample_type s, bit known, angles_type known_angles);
      int gap;
      if ($urandom_range(0, 24) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= s;
      req_known <= known;
      req_known_angles <= known_angles;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_csr(acctilt_pkg::csr_index_type idx,
                            logic [acctilt_pkg::OFFSET_W-1:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_offsets(int roll_off, int pitch_off, bit poke_unused);
      write_csr(acctilt_pkg::CSR_ROLL_OFFSET, roll_off[acctilt_pkg::OFFSET_W-1:0]);
      write_csr(acctilt_pkg::CSR_PITCH_OFFSET, pitch_off[acctilt_pkg::OFFSET_W-1:0]);
      if (poke_unused)
         write_csr(acctilt_pkg::csr_index_type'($urandom_range(CSR_FIRST_UNUSED, 255)),
                   acctilt_pkg::OFFSET_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // predicted or typed-in result of each accepted sample
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         pending_angles.push_back(req_known ? req_known_angles : tilt_angles_of(req_tdata));
   end

   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == acctilt_pkg::CSR_ROLL_OFFSET) roll_trim <= csr_data;
         else if (csr_index == acctilt_pkg::CSR_PITCH_OFFSET) pitch_trim <= csr_data;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got_angles = rsp_tdata[acctilt_pkg::ROLL_W+acctilt_pkg::PITCH_W-1:0];
         if (pending_angles.size() == 0) begin
            flag_error($sformatf("unexpected result roll %0d pitch %0d",
                                 got_angles.roll, got_angles.pitch));
         end else begin
            want_angles = pending_angles.pop_front();
            if (got_angles.roll !== want_angles.roll)
               flag_error($sformatf("roll mismatch: expected %0d, got %0d",
                                    want_angles.roll, got_angles.roll));
            if (got_angles.pitch !== want_angles.pitch)
               flag_error($sformatf("pitch mismatch: expected %0d, got %0d",
                                    want_angles.pitch, got_angles.pitch));
         end
         if ($urandom_range(0, 24) == 0) rsp_steady = !rsp_steady;
         rsp_gap = rsp_steady ? 0 : $urandom_range(0, 19);
         if (rsp_gap != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold <= rsp_gap - 1;
         end
      end else if (!rsp_tready) begin
         if (rsp_hold == 0) rsp_tready <= 1'b1;
         else rsp_hold <= rsp_hold - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("accel_tilt_angles regression: fail");
         $finish;
      end
   end

   initial begin
      sample_type s;
      angles_type typed;
      int roll_off;
      int pitch_off;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_rows[n]) begin
         s.accel_x = corner_rows[n].x[SAMPLE_W-1:0];
         s.accel_y = corner_rows[n].y[SAMPLE_W-1:0];
         s.accel_z = corner_rows[n].z[SAMPLE_W-1:0];
         typed.roll = corner_rows[n].roll[acctilt_pkg::ROLL_W-1:0];
         typed.pitch = corner_rows[n].pitch[acctilt_pkg::PITCH_W-1:0];
         send_sample(s, corner_rows[n].known, typed);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         roll_off = PHASE_ROLL[p];
         pitch_off = PHASE_PITCH[p];
         if (p == 4 || p == 5) begin
            roll_off = int'($urandom_range(0, 2 * OFFSET_MAX)) - OFFSET_MAX;
            pitch_off = int'($urandom_range(0, 2 * OFFSET_MAX)) - OFFSET_MAX;
         end
         load_offsets(roll_off, pitch_off, p == 1 || p == 5);
         // zero vector gives back the offsets themselves
         typed.roll = roll_off[acctilt_pkg::ROLL_W-1:0];
         typed.pitch = pitch_off[acctilt_pkg::PITCH_W-1:0];
         send_sample('0, 1'b1, typed);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_sample(random_sample(), 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_angles.size() == 0)
         $display("accel_tilt_angles regression: pass");
      else
         $display("accel_tilt_angles regression: fail");
      $finish;
   end

endmodule
